// ===== sv/amo_alu_pkg.sv =====
// types, codes and helper functions shared by the atomic memory operation unit
// no dependencies

package amo_alu_pkg;

    // opcode values
    localparam logic [3:0] OP_CAS  = 4'd0;
    localparam logic [3:0] OP_SWP  = 4'd1;
    localparam logic [3:0] OP_ADD  = 4'd2;
    localparam logic [3:0] OP_CLR  = 4'd3;
    localparam logic [3:0] OP_EOR  = 4'd4;
    localparam logic [3:0] OP_SET  = 4'd5;
    localparam logic [3:0] OP_SMAX = 4'd6;
    localparam logic [3:0] OP_SMIN = 4'd7;
    localparam logic [3:0] OP_UMAX = 4'd8;
    localparam logic [3:0] OP_UMIN = 4'd9;

    // access size codes
    localparam logic [2:0] SZ_1  = 3'd0;
    localparam logic [2:0] SZ_2  = 3'd1;
    localparam logic [2:0] SZ_4  = 3'd2;
    localparam logic [2:0] SZ_8  = 3'd3;
    localparam logic [2:0] SZ_16 = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_INVALID     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    // one request transaction
    typedef struct packed {
        logic [3:0]  opcode;
        logic [2:0]  size_code;
        logic [63:0] mem_lo;
        logic [63:0] mem_hi;
        logic [63:0] operand_lo;
        logic [63:0] operand_hi;
        logic [63:0] compare_lo;
        logic [63:0] compare_hi;
    } req_t;

    // one result transaction
    typedef struct packed {
        logic [63:0] write_lo;
        logic [63:0] write_hi;
        logic        do_write;
        logic [63:0] prior_lo;
        logic [63:0] prior_hi;
        logic [1:0]  status;
    } rsp_t;

    // byte-lane mask for access sizes below 16 bytes
    function automatic logic [63:0] size_mask(input logic [2:0] sc);
        logic [63:0] m;
        begin
            unique case (sc)
                SZ_1:    m = 64'h0000_0000_0000_00ff;
                SZ_2:    m = 64'h0000_0000_0000_ffff;
                SZ_4:    m = 64'h0000_0000_ffff_ffff;
                default: m = 64'hffff_ffff_ffff_ffff;
            endcase
            return m;
        end
    endfunction

    // sign bit of the access width
    function automatic logic [63:0] sign_bit(input logic [2:0] sc);
        logic [63:0] s;
        begin
            unique case (sc)
                SZ_1:    s = 64'h0000_0000_0000_0080;
                SZ_2:    s = 64'h0000_0000_0000_8000;
                SZ_4:    s = 64'h0000_0000_8000_0000;
                default: s = 64'h8000_0000_0000_0000;
            endcase
            return s;
        end
    endfunction

endpackage

// ===== sv/amo_alu_core.sv =====
// combinational read-modify-write datapath for one atomic transaction
// depends on amo_alu_pkg

module amo_alu_core (
    input  amo_alu_pkg::req_t req,
    output amo_alu_pkg::rsp_t rsp
);

    logic [63:0] mask;
    logic [63:0] sign;
    logic [63:0] o;
    logic [63:0] v;
    logic [63:0] c;
    logic [63:0] os;
    logic [63:0] vs;
    logic [63:0] r;
    logic        wr;

    // operands masked to the access size, signed views with the sign bit flipped
    assign mask = amo_alu_pkg::size_mask(req.size_code);
    assign sign = amo_alu_pkg::sign_bit(req.size_code);
    assign o    = req.mem_lo & mask;
    assign v    = req.operand_lo & mask;
    assign c    = req.compare_lo & mask;
    assign os   = o ^ sign;
    assign vs   = v ^ sign;

    // narrow operation result
    always_comb begin
        r  = '0;
        wr = 1'b1;
        unique case (req.opcode)
            amo_alu_pkg::OP_CAS: begin
                if (o == c) begin
                    r = v;
                end else begin
                    wr = 1'b0;
                end
            end
            amo_alu_pkg::OP_SWP:  r = v;
            amo_alu_pkg::OP_ADD:  r = o + v;
            amo_alu_pkg::OP_CLR:  r = o & ~v;
            amo_alu_pkg::OP_EOR:  r = o ^ v;
            amo_alu_pkg::OP_SET:  r = o | v;
            amo_alu_pkg::OP_SMAX: r = (os > vs) ? o : v;
            amo_alu_pkg::OP_SMIN: r = (os < vs) ? o : v;
            amo_alu_pkg::OP_UMAX: r = (o > v) ? o : v;
            default:              r = (o < v) ? o : v;
        endcase
    end

    // select by size and validity
    always_comb begin
        rsp = '0;
        if (req.opcode > amo_alu_pkg::OP_UMIN || req.size_code > amo_alu_pkg::SZ_16) begin
            rsp.status = amo_alu_pkg::ST_INVALID;
        end else if (req.size_code == amo_alu_pkg::SZ_16) begin
            unique case (req.opcode)
                amo_alu_pkg::OP_CAS: begin
                    rsp.prior_lo = req.mem_lo;
                    rsp.prior_hi = req.mem_hi;
                    if (req.mem_lo == req.compare_lo && req.mem_hi == req.compare_hi) begin
                        rsp.write_lo = req.operand_lo;
                        rsp.write_hi = req.operand_hi;
                        rsp.do_write = 1'b1;
                    end
                end
                amo_alu_pkg::OP_SWP: begin
                    rsp.prior_lo = req.mem_lo;
                    rsp.prior_hi = req.mem_hi;
                    rsp.write_lo = req.operand_lo;
                    rsp.write_hi = req.operand_hi;
                    rsp.do_write = 1'b1;
                end
                amo_alu_pkg::OP_CLR: begin
                    rsp.prior_lo = req.mem_lo;
                    rsp.prior_hi = req.mem_hi;
                    rsp.write_lo = req.mem_lo & ~req.operand_lo;
                    rsp.write_hi = req.mem_hi & ~req.operand_hi;
                    rsp.do_write = 1'b1;
                end
                amo_alu_pkg::OP_SET: begin
                    rsp.prior_lo = req.mem_lo;
                    rsp.prior_hi = req.mem_hi;
                    rsp.write_lo = req.mem_lo | req.operand_lo;
                    rsp.write_hi = req.mem_hi | req.operand_hi;
                    rsp.do_write = 1'b1;
                end
                default: begin
                    rsp.status = amo_alu_pkg::ST_UNSUPPORTED;
                end
            endcase
        end else begin
            rsp.prior_lo = o;
            rsp.write_lo = r & mask;
            rsp.do_write = wr;
        end
    end

endmodule

// ===== sv/atomic_memory_op_alu_top.sv =====
// top level of the atomic memory operation unit: input register, datapath, result register
// depends on amo_alu_pkg and amo_alu_core

// Atomic read-modify-write unit. Each transaction carries the current memory word, an
// operand, a compare value, an opcode and an access size, and returns the value to store,
// a write flag, the old value and a status. The unit takes one transaction per cycle while
// no result waits on m_ready, through two registers, the input register and the result register,
// with the opcode datapath (a 64-bit add or compare and selection) between them. The two
// registers stall independently, so a new transaction is still taken while a finished
// result waits on m_ready as long as the input register is free.

module atomic_memory_op_alu_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_opcode,
    input  logic [2:0]  s_size_code,
    input  logic [63:0] s_mem_lo,
    input  logic [63:0] s_mem_hi,
    input  logic [63:0] s_operand_lo,
    input  logic [63:0] s_operand_hi,
    input  logic [63:0] s_compare_lo,
    input  logic [63:0] s_compare_hi,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_write_lo,
    output logic [63:0] m_write_hi,
    output logic        m_do_write,
    output logic [63:0] m_prior_lo,
    output logic [63:0] m_prior_hi,
    output logic [1:0]  m_status
);

    amo_alu_pkg::req_t req_reg, req_next;
    amo_alu_pkg::rsp_t rsp_reg, rsp_next;
    amo_alu_pkg::rsp_t rsp_comb;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;
    logic              in_take;
    logic              out_take;

    // handshake between the two register stages
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_take  = s_valid && s_ready;
    assign out_take = in_valid_reg && out_free;

    // input register next state
    always_comb begin
        req_next      = req_reg;
        in_valid_next = in_valid_reg;
        if (in_take) begin
            req_next.opcode     = s_opcode;
            req_next.size_code  = s_size_code;
            req_next.mem_lo     = s_mem_lo;
            req_next.mem_hi     = s_mem_hi;
            req_next.operand_lo = s_operand_lo;
            req_next.operand_hi = s_operand_hi;
            req_next.compare_lo = s_compare_lo;
            req_next.compare_hi = s_compare_hi;
            in_valid_next       = 1'b1;
        end else if (out_free) begin
            in_valid_next = 1'b0;
        end
    end

    // datapath
    amo_alu_core u_core (
        .req (req_reg),
        .rsp (rsp_comb)
    );

    // result register next state
    always_comb begin
        rsp_next       = rsp_reg;
        out_valid_next = out_valid_reg;
        if (out_take) begin
            rsp_next       = rsp_comb;
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    // result ports
    assign m_valid    = out_valid_reg;
    assign m_write_lo = rsp_reg.write_lo;
    assign m_write_hi = rsp_reg.write_hi;
    assign m_do_write = rsp_reg.do_write;
    assign m_prior_lo = rsp_reg.prior_lo;
    assign m_prior_hi = rsp_reg.prior_hi;
    assign m_status   = rsp_reg.status;

    // an error status never writes and returns no old value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != amo_alu_pkg::ST_OK)
            |-> (!m_do_write && m_prior_lo == 64'd0 && m_prior_hi == 64'd0))
        else $error("error status with write or old value");

    // no write means zero store value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_do_write) |-> (m_write_lo == 64'd0 && m_write_hi == 64'd0))
        else $error("store value nonzero without write");

    // an empty input register always takes a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

    // a held transaction is not dropped while the result stage stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_valid && !m_ready) |=> (in_valid_reg && m_valid))
        else $error("transaction lost during stall");

endmodule

// ===== tb/atomic_memory_op_alu_top_tb.sv =====
// testbench for atomic_memory_op_alu_top: directed and random atomic transactions
// under several idle and stall mixes, checked against an in-bench predictor
// depends on amo_alu_pkg and the atomic_memory_op_alu_top rtl

module atomic_memory_op_alu_top_tb;

    // opcode and size values outside the defined sets
    localparam logic [3:0] OP_FIRST_RESERVED = 4'd10;
    localparam logic [3:0] OP_LAST_RESERVED  = 4'd15;
    localparam logic [2:0] SZ_FIRST_RESERVED = 3'd5;
    localparam logic [2:0] SZ_LAST_RESERVED  = 3'd7;

    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 8;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_opcode     = '0;
    logic [2:0]  s_size_code  = '0;
    logic [63:0] s_mem_lo     = '0;
    logic [63:0] s_mem_hi     = '0;
    logic [63:0] s_operand_lo = '0;
    logic [63:0] s_operand_hi = '0;
    logic [63:0] s_compare_lo = '0;
    logic [63:0] s_compare_hi = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_write_lo;
    logic [63:0] m_write_hi;
    logic        m_do_write;
    logic [63:0] m_prior_lo;
    logic [63:0] m_prior_hi;
    logic [1:0]  m_status;

    amo_alu_pkg::req_t pending_reqs[$];
    amo_alu_pkg::rsp_t expected_rsps[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int idle_cycles    = 0;

    amo_alu_pkg::rsp_t observed_rsp;
    amo_alu_pkg::rsp_t wanted_rsp;
    amo_alu_pkg::req_t next_req;

    atomic_memory_op_alu_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_size_code  (s_size_code),
        .s_mem_lo     (s_mem_lo),
        .s_mem_hi     (s_mem_hi),
        .s_operand_lo (s_operand_lo),
        .s_operand_hi (s_operand_hi),
        .s_compare_lo (s_compare_lo),
        .s_compare_hi (s_compare_hi),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_write_lo   (m_write_lo),
        .m_write_hi   (m_write_hi),
        .m_do_write   (m_do_write),
        .m_prior_lo   (m_prior_lo),
        .m_prior_hi   (m_prior_hi),
        .m_status     (m_status)
    );

    always #10 aclk = ~aclk;

    // byte lanes covered by an access below 16 bytes
    function automatic logic [63:0] lane_mask(input logic [2:0] sc);
        if (sc >= amo_alu_pkg::SZ_8) return '1;
        return (64'd1 << (8 << sc)) - 64'd1;
    endfunction

    // expected outcome of one atomic transaction
    function automatic amo_alu_pkg::rsp_t predict_amo(input amo_alu_pkg::req_t rq);
        amo_alu_pkg::rsp_t r;
        logic [63:0]       m, sgn, o, v, c, res;
        int                bits;
        r = '0;
        if (rq.opcode > amo_alu_pkg::OP_UMIN || rq.size_code > amo_alu_pkg::SZ_16) begin
            r.status = amo_alu_pkg::ST_INVALID;
        end else if (rq.size_code == amo_alu_pkg::SZ_16) begin
            r.status = amo_alu_pkg::ST_OK;
            r.prior_lo = rq.mem_lo;
            r.prior_hi = rq.mem_hi;
            r.do_write = 1'b1;
            case (rq.opcode)
                amo_alu_pkg::OP_CAS: begin
                    if (rq.mem_lo == rq.compare_lo && rq.mem_hi == rq.compare_hi) begin
                        r.write_lo = rq.operand_lo;
                        r.write_hi = rq.operand_hi;
                    end else begin
                        r.do_write = 1'b0;
                    end
                end
                amo_alu_pkg::OP_SWP: begin
                    r.write_lo = rq.operand_lo;
                    r.write_hi = rq.operand_hi;
                end
                amo_alu_pkg::OP_CLR: begin
                    r.write_lo = rq.mem_lo & ~rq.operand_lo;
                    r.write_hi = rq.mem_hi & ~rq.operand_hi;
                end
                amo_alu_pkg::OP_SET: begin
                    r.write_lo = rq.mem_lo | rq.operand_lo;
                    r.write_hi = rq.mem_hi | rq.operand_hi;
                end
                default: begin
                    // wide add, eor, min and max are not supported, all data fields stay zero
                    r = '0;
                    r.status = amo_alu_pkg::ST_UNSUPPORTED;
                end
            endcase
        end else begin
            m    = lane_mask(rq.size_code);
            bits = 8 << rq.size_code;
            sgn  = 64'd1 << (bits - 1);
            o    = rq.mem_lo & m;
            v    = rq.operand_lo & m;
            c    = rq.compare_lo & m;
            res  = '0;
            r.status   = amo_alu_pkg::ST_OK;
            r.prior_lo = o;
            r.do_write = 1'b1;
            // signed compares done as unsigned ones with the sign bit flipped
            case (rq.opcode)
                amo_alu_pkg::OP_CAS: begin
                    if (o == c) res = v;
                    else r.do_write = 1'b0;
                end
                amo_alu_pkg::OP_SWP:  res = v;
                amo_alu_pkg::OP_ADD:  res = o + v;
                amo_alu_pkg::OP_CLR:  res = o & ~v;
                amo_alu_pkg::OP_EOR:  res = o ^ v;
                amo_alu_pkg::OP_SET:  res = o | v;
                amo_alu_pkg::OP_SMAX: res = ((o ^ sgn) > (v ^ sgn)) ? o : v;
                amo_alu_pkg::OP_SMIN: res = ((o ^ sgn) < (v ^ sgn)) ? o : v;
                amo_alu_pkg::OP_UMAX: res = (o > v) ? o : v;
                default:              res = (o < v) ? o : v;
            endcase
            r.write_lo = res & m;
        end
        return r;
    endfunction

    // biased data word: corners, single bits and plain random
    function automatic logic [63:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 64'($urandom_range(255));
            3:       return 64'd1 << $urandom_range(63);
            4:       return ~(64'd1 << $urandom_range(63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_item(input logic [3:0] op, input logic [2:0] sc,
                              input logic [63:0] mem_lo, input logic [63:0] mem_hi,
                              input logic [63:0] opnd_lo, input logic [63:0] opnd_hi,
                              input logic [63:0] cmp_lo, input logic [63:0] cmp_hi);
        amo_alu_pkg::req_t rq;
        rq.opcode     = op;
        rq.size_code  = sc;
        rq.mem_lo     = mem_lo;
        rq.mem_hi     = mem_hi;
        rq.operand_lo = opnd_lo;
        rq.operand_hi = opnd_hi;
        rq.compare_lo = cmp_lo;
        rq.compare_hi = cmp_hi;
        pending_reqs.push_back(rq);
    endtask

    // mostly legal transactions, cas compares often matching, some reserved codes
    task automatic queue_random(input int count);
        logic [3:0]  op;
        logic [2:0]  sc;
        logic [63:0] mem_lo, mem_hi, cmp_lo, cmp_hi;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(99) < 8) ?
                 4'($urandom_range(OP_LAST_RESERVED, OP_FIRST_RESERVED)) :
                 4'($urandom_range(amo_alu_pkg::OP_UMIN, amo_alu_pkg::OP_CAS));
            sc = ($urandom_range(99) < 8) ?
                 3'($urandom_range(SZ_LAST_RESERVED, SZ_FIRST_RESERVED)) :
                 3'($urandom_range(amo_alu_pkg::SZ_16, amo_alu_pkg::SZ_1));
            mem_lo = pick_word();
            mem_hi = pick_word();
            case ($urandom_range(3))
                0, 1: begin
                    cmp_lo = (mem_lo & lane_mask(sc)) | (pick_word() & ~lane_mask(sc));
                    cmp_hi = mem_hi;
                end
                2: begin
                    cmp_lo = mem_lo;
                    cmp_hi = mem_hi ^ (64'd1 << $urandom_range(63));
                end
                default: begin
                    cmp_lo = pick_word();
                    cmp_hi = pick_word();
                end
            endcase
            queue_item(op, sc, mem_lo, mem_hi, pick_word(), pick_word(), cmp_lo, cmp_hi);
        end
    endtask

    // hold the sender off until every queued transaction has come back
    task automatic drain();
        while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0)
            @(posedge aclk);
    endtask

    // driver: present queued transactions, predict each one as it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                next_req.opcode     = s_opcode;
                next_req.size_code  = s_size_code;
                next_req.mem_lo     = s_mem_lo;
                next_req.mem_hi     = s_mem_hi;
                next_req.operand_lo = s_operand_lo;
                next_req.operand_hi = s_operand_hi;
                next_req.compare_lo = s_compare_lo;
                next_req.compare_hi = s_compare_hi;
                expected_rsps.push_back(predict_amo(next_req));
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = pending_reqs.pop_front();
                    s_opcode     <= next_req.opcode;
                    s_size_code  <= next_req.size_code;
                    s_mem_lo     <= next_req.mem_lo;
                    s_mem_hi     <= next_req.mem_hi;
                    s_operand_lo <= next_req.operand_lo;
                    s_operand_hi <= next_req.operand_hi;
                    s_compare_lo <= next_req.compare_lo;
                    s_compare_hi <= next_req.compare_hi;
                    s_valid      <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            observed_rsp.write_lo = m_write_lo;
            observed_rsp.write_hi = m_write_hi;
            observed_rsp.do_write = m_do_write;
            observed_rsp.prior_lo = m_prior_lo;
            observed_rsp.prior_hi = m_prior_hi;
            observed_rsp.status   = m_status;
            if (expected_rsps.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result: write=%h_%h do_write=%b prior=%h_%h status=%0d",
                             m_write_hi, m_write_lo, m_do_write, m_prior_hi, m_prior_lo,
                             m_status);
                mismatch_count <= mismatch_count + 1;
            end else begin
                wanted_rsp = expected_rsps.pop_front();
                if (observed_rsp.write_lo !== wanted_rsp.write_lo ||
                    observed_rsp.write_hi !== wanted_rsp.write_hi ||
                    observed_rsp.do_write !== wanted_rsp.do_write ||
                    observed_rsp.prior_lo !== wanted_rsp.prior_lo ||
                    observed_rsp.prior_hi !== wanted_rsp.prior_hi ||
                    observed_rsp.status   !== wanted_rsp.status) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("mismatch exp: write=%h_%h do_write=%b prior=%h_%h status=%0d",
                                 wanted_rsp.write_hi, wanted_rsp.write_lo, wanted_rsp.do_write,
                                 wanted_rsp.prior_hi, wanted_rsp.prior_lo, wanted_rsp.status);
                        $display("         got: write=%h_%h do_write=%b prior=%h_%h status=%0d",
                                 m_write_hi, m_write_lo, m_do_write, m_prior_hi, m_prior_lo,
                                 m_status);
                    end
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    // watchdog: cycles with work outstanding but no transaction on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0) begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners, no idling
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // cas: match with junk above the lanes, miss, wide match, wide miss in high half
        queue_item(amo_alu_pkg::OP_CAS, amo_alu_pkg::SZ_1, 64'hdead_beef_0000_00ff, 64'h0,
                   64'h5a, 64'h0, 64'h1234_0000_0000_00ff, 64'h0);
        queue_item(amo_alu_pkg::OP_CAS, amo_alu_pkg::SZ_8, 64'h0, 64'h0, '1, '1,
                   64'h1, 64'h0);
        queue_item(amo_alu_pkg::OP_CAS, amo_alu_pkg::SZ_16, '1, '1,
                   64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, '1, '1);
        queue_item(amo_alu_pkg::OP_CAS, amo_alu_pkg::SZ_16, 64'h55,
                   64'h8000_0000_0000_0000, '1, '1, 64'h55, 64'h0);
        queue_item(amo_alu_pkg::OP_SWP, amo_alu_pkg::SZ_2, 64'hffff_ffff_ffff_1234, 64'h0,
                   64'hffff_ffff_ffff_abcd, '1, 64'h0, 64'h0);
        queue_item(amo_alu_pkg::OP_SWP, amo_alu_pkg::SZ_16, 64'h0, 64'h0, '1, '1,
                   64'h0, 64'h0);
        // add wrapping at the access width
        queue_item(amo_alu_pkg::OP_ADD, amo_alu_pkg::SZ_1, 64'hff, 64'h0, 64'h01, 64'h0,
                   64'h0, 64'h0);
        queue_item(amo_alu_pkg::OP_ADD, amo_alu_pkg::SZ_8, '1, 64'h0, '1, 64'h0,
                   64'h0, 64'h0);
        queue_item(amo_alu_pkg::OP_CLR, amo_alu_pkg::SZ_4, '1, '1, 64'h0f0f_0f0f_f0f0_f0f0,
                   64'h0, 64'h0, 64'h0);
        queue_item(amo_alu_pkg::OP_CLR, amo_alu_pkg::SZ_16, '1, 64'haaaa_aaaa_aaaa_aaaa,
                   64'h1, '1, 64'h0, 64'h0);
        queue_item(amo_alu_pkg::OP_EOR, amo_alu_pkg::SZ_8, 64'haaaa_aaaa_aaaa_aaaa, 64'h0,
                   '1, 64'h0, 64'h0, 64'h0);
        queue_item(amo_alu_pkg::OP_SET, amo_alu_pkg::SZ_2, 64'h0, 64'h0, '1, '1,
                   64'h0, 64'h0);
        queue_item(amo_alu_pkg::OP_SET, amo_alu_pkg::SZ_16, 64'h0, 64'h8000_0000_0000_0001,
                   64'h1, 64'h2, 64'h0, 64'h0);
        // signed compares at the sign boundary of each width
        queue_item(amo_alu_pkg::OP_SMAX, amo_alu_pkg::SZ_1, 64'h80, 64'h0, 64'h7f, 64'h0,
                   64'h0, 64'h0);
        queue_item(amo_alu_pkg::OP_SMIN, amo_alu_pkg::SZ_2, 64'h8000, 64'h0, 64'h7fff,
                   64'h0, 64'h0, 64'h0);
        queue_item(amo_alu_pkg::OP_SMAX, amo_alu_pkg::SZ_8, 64'h7fff_ffff_ffff_ffff, 64'h0,
                   64'h8000_0000_0000_0000, 64'h0, 64'h0, 64'h0);
        queue_item(amo_alu_pkg::OP_SMIN, amo_alu_pkg::SZ_4, 64'h0000_0000_ffff_ffff, 64'h0,
                   64'h1, 64'h0, 64'h0, 64'h0);
        queue_item(amo_alu_pkg::OP_UMAX, amo_alu_pkg::SZ_4, 64'hffff_ffff, 64'h0, 64'h0,
                   64'h0, 64'h0, 64'h0);
        queue_item(amo_alu_pkg::OP_UMIN, amo_alu_pkg::SZ_8, '1, 64'h0, 64'h1, 64'h0,
                   64'h0, 64'h0);
        // arithmetic at 16 bytes is unsupported
        queue_item(amo_alu_pkg::OP_ADD, amo_alu_pkg::SZ_16, '1, '1, '1, '1, '1, '1);
        queue_item(amo_alu_pkg::OP_UMIN, amo_alu_pkg::SZ_16, 64'h1, 64'h2, 64'h3, 64'h4,
                   64'h5, 64'h6);
        // reserved opcodes and sizes
        queue_item(OP_LAST_RESERVED, amo_alu_pkg::SZ_4, '1, '1, '1, '1, '1, '1);
        queue_item(amo_alu_pkg::OP_CAS, SZ_LAST_RESERVED, '1, '1, '1, '1, '1, '1);
        queue_item(OP_FIRST_RESERVED, SZ_FIRST_RESERVED, '1, '1, '1, '1, '1, '1);
        drain();

        // random phases with different idle mixes
        queue_random(350);
        drain();
        send_idle_pct = 83;
        queue_random(300);
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        queue_random(300);
        drain();
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        queue_random(300);
        drain();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
